FILE: rtl/single_source_shortest_paths_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the shortest path unit
// Short forms for clocked concurrent assertions, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_UNIT_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_UNIT_ASSERT_SVH

// Checked only while reset is released.
`define SSP_ASSERT_CLK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);

// Checked on every edge, reset included.
`define SSP_ASSERT_ALL(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) expr) else $error(msg);

`endif

FILE: rtl/ssp_pkg.sv
// ---------------------------------------------------------------------------
// Shortest path unit package
// Payload types, field widths, register indexes and distance saturation.
// ---------------------------------------------------------------------------
package ssp_pkg;

  localparam int DEF_MAX_NODES = 16;
  localparam int DEF_MAX_EDGES = 64;

  localparam int NODE_W      = 4;
  localparam int WEIGHT_W    = 16;
  localparam int DIST_W      = 24;
  localparam int NUM_NODES_W = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_NODES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 1'b1;

  localparam logic [NUM_NODES_W-1:0] NUM_NODES_RST = 5'd16;
  localparam logic [NODE_W-1:0]      SOURCE_RST    = 4'd0;

  typedef struct packed {
    logic [NODE_W-1:0]          edge_from;
    logic [NODE_W-1:0]          edge_to;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic                       last_edge;
  } edge_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]        node_index;
    logic signed [DIST_W-1:0] path_distance;
    logic                     reachable;
    logic [NODE_W-1:0]        predecessor;
    logic                     has_predecessor;
    logic                     last_node;
  } node_result_t;

  // Clamp a sum one bit wider than a distance back into the distance range.
  function automatic logic signed [DIST_W-1:0] sat_dist(input logic [DIST_W:0] s);
    logic signed [DIST_W-1:0] r;
    if (s[DIST_W] != s[DIST_W-1]) begin
      r = s[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      r = s[DIST_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/single_source_shortest_paths_unit.sv
// ---------------------------------------------------------------------------
// Single-source shortest path unit
// Stores a directed edge list and runs Bellman-Ford relaxation over it.
// ---------------------------------------------------------------------------
// Edges arrive on the in_ channel, one request per cycle, and are stored in
// load order. Edges beyond MAX_EDGES are dropped. The request with last_edge
// set is stored too and starts the computation; in_stall stays high until the
// last result has been taken. Relaxation runs num_nodes-1 passes over the
// stored edges unless the source is out of range or no edge is stored; each
// edge goes through edge memory read, node memory read, add and saturate,
// and compare and write back. Then one result per node comes out on the
// out_ channel in ascending order, the next once the last one is taken;
// a stalled result holds its value. Configuration writes on cfg_ are
// always ready and belong between graphs. Reset clears the edge count and
// the node flags and returns to loading; no memory clearing pass is needed.
// ---------------------------------------------------------------------------
module single_source_shortest_paths_unit #(
  parameter int MAX_NODES = ssp_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = ssp_pkg::DEF_MAX_EDGES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ssp_pkg::edge_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ssp_pkg::node_result_t           out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ssp_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW1 = $clog2(MAX_EDGES + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_EREAD  = 4'd2;
  localparam logic [3:0] S_NREAD  = 4'd3;
  localparam logic [3:0] S_CALC   = 4'd4;
  localparam logic [3:0] S_UPDATE = 4'd5;
  localparam logic [3:0] S_OREAD  = 4'd6;
  localparam logic [3:0] S_OLOAD  = 4'd7;
  localparam logic [3:0] S_OWAIT  = 4'd8;

  typedef struct packed {
    logic [NODE_W-1:0]          tail;
    logic [NODE_W-1:0]          head;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_entry_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic [NODE_W-1:0]        parent;
  } node_entry_t;

  edge_entry_t edge_mem [MAX_EDGES];
  node_entry_t node_mem [MAX_NODES];

  logic [3:0]             state_r, state_nxt;
  logic [NUM_NODES_W-1:0] num_nodes_r, num_nodes_nxt;
  logic [NODE_W-1:0]      source_r, source_nxt;
  logic [EW1-1:0]         edge_cnt_r, edge_cnt_nxt;
  logic [EW1-1:0]         eidx_r, eidx_nxt;
  logic [NCW-1:0]         n_r, n_nxt;
  logic [NCW-1:0]         pass_r, pass_nxt;
  logic [NCW-1:0]         i_r, i_nxt;
  logic [MAX_NODES-1:0]   reached_r, reached_nxt;
  logic [MAX_NODES-1:0]   pvalid_r, pvalid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  node_result_t           out_r, out_nxt;

  edge_entry_t              edge_rd_r;
  node_entry_t              node_a_r, node_b_r;
  logic                     skip_r;
  logic signed [DIST_W-1:0] cand_r;

  logic              in_acc;
  logic              store_edge;
  logic [7:0]        nn_w;
  logic [7:0]        n_eff;
  logic              src_ok;
  logic [NW-1:0]     src_idx, u_idx, v_idx, i_idx;
  logic              relax;
  logic              node_we;
  logic [NW-1:0]     node_waddr;
  node_entry_t       node_wdata;
  logic [DIST_W:0]   sum_w;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign store_edge = in_acc && (edge_cnt_r < EW1'(MAX_EDGES));
  assign nn_w       = 8'(num_nodes_r);
  assign n_eff      = (nn_w == 8'd0) ? 8'd1 :
                      (nn_w > 8'(MAX_NODES)) ? 8'(MAX_NODES) : nn_w;
  assign src_ok     = 8'(source_r) < 8'(n_r);
  assign src_idx    = NW'(source_r);
  assign u_idx      = NW'(edge_rd_r.tail);
  assign v_idx      = NW'(edge_rd_r.head);
  assign i_idx      = i_r[NW-1:0];

  // Relaxation from a reached tail; an unreached head always takes the value.
  assign relax = (state_r == S_UPDATE) && !skip_r &&
                 (!reached_r[v_idx] || (cand_r < node_b_r.distance));

  assign sum_w = {node_a_r.distance[DIST_W-1], node_a_r.distance} +
                 {{(DIST_W + 1 - WEIGHT_W){edge_rd_r.weight[WEIGHT_W-1]}},
                  edge_rd_r.weight};

  always_comb begin
    node_we    = 1'b0;
    node_waddr = v_idx;
    node_wdata = '{distance: cand_r, parent: edge_rd_r.tail};
    if (state_r == S_START) begin
      node_we    = src_ok;
      node_waddr = src_idx;
      node_wdata = '{distance: '0, parent: '0};
    end else if (relax) begin
      node_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    num_nodes_nxt = num_nodes_r;
    source_nxt    = source_r;
    edge_cnt_nxt  = edge_cnt_r;
    eidx_nxt      = eidx_r;
    n_nxt         = n_r;
    pass_nxt      = pass_r;
    i_nxt         = i_r;
    reached_nxt   = reached_r;
    pvalid_nxt    = pvalid_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_NODES:   num_nodes_nxt = cfg_data[NUM_NODES_W-1:0];
        REG_SOURCE_NODE: source_nxt = cfg_data[NODE_W-1:0];
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (store_edge) begin
          edge_cnt_nxt = edge_cnt_r + EW1'(1);
        end
        if (in_acc && in_data.last_edge) begin
          n_nxt     = NCW'(n_eff);
          state_nxt = S_START;
        end
      end
      S_START: begin
        reached_nxt = '0;
        pvalid_nxt  = '0;
        if (src_ok) begin
          reached_nxt[src_idx] = 1'b1;
        end
        eidx_nxt = '0;
        pass_nxt = '0;
        i_nxt    = '0;
        if (!src_ok || (n_r == NCW'(1)) || (edge_cnt_r == '0)) begin
          state_nxt = S_OREAD;
        end else begin
          state_nxt = S_EREAD;
        end
      end
      S_EREAD: state_nxt = S_NREAD;
      S_NREAD: state_nxt = S_CALC;
      S_CALC:  state_nxt = S_UPDATE;
      S_UPDATE: begin
        if (relax) begin
          reached_nxt[v_idx] = 1'b1;
          pvalid_nxt[v_idx]  = 1'b1;
        end
        if ((eidx_r + EW1'(1)) == edge_cnt_r) begin
          eidx_nxt = '0;
          if (((NCW+1)'(pass_r) + (NCW+1)'(2)) == (NCW+1)'(n_r)) begin
            state_nxt = S_OREAD;
          end else begin
            pass_nxt  = pass_r + NCW'(1);
            state_nxt = S_EREAD;
          end
        end else begin
          eidx_nxt  = eidx_r + EW1'(1);
          state_nxt = S_EREAD;
        end
      end
      S_OREAD: state_nxt = S_OLOAD;
      S_OLOAD: begin
        out_nxt.node_index      = NODE_W'(i_r);
        out_nxt.reachable       = reached_r[i_idx];
        out_nxt.path_distance   = reached_r[i_idx] ? node_a_r.distance : '0;
        out_nxt.has_predecessor = pvalid_r[i_idx];
        out_nxt.predecessor     = pvalid_r[i_idx] ? node_a_r.parent : '0;
        out_nxt.last_node       = ((NCW+1)'(i_r) + (NCW+1)'(1)) == (NCW+1)'(n_r);
        out_valid_nxt           = 1'b1;
        state_nxt               = S_OWAIT;
      end
      S_OWAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_node) begin
            edge_cnt_nxt = '0;
            state_nxt    = S_IDLE;
          end else begin
            i_nxt     = i_r + NCW'(1);
            state_nxt = S_OREAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_nodes_r <= NUM_NODES_RST;
      source_r    <= SOURCE_RST;
      edge_cnt_r  <= '0;
      eidx_r      <= '0;
      n_r         <= '0;
      pass_r      <= '0;
      i_r         <= '0;
      reached_r   <= '0;
      pvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_nodes_r <= num_nodes_nxt;
      source_r    <= source_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      eidx_r      <= eidx_nxt;
      n_r         <= n_nxt;
      pass_r      <= pass_nxt;
      i_r         <= i_nxt;
      reached_r   <= reached_nxt;
      pvalid_r    <= pvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Edge store: written while loading, read once per relaxation step.
  always_ff @(posedge clk) begin
    if (store_edge) begin
      edge_mem[edge_cnt_r[EAW-1:0]] <= '{tail:   in_data.edge_from,
                                          head:   in_data.edge_to,
                                          weight: in_data.edge_weight};
    end
    if (state_r == S_EREAD) begin
      edge_rd_r <= edge_mem[eidx_r[EAW-1:0]];
    end
  end

  // Node store: each edge finishes its write back before the next edge reads,
  // so reads never overlap a pending write to the same entry.
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (state_r == S_NREAD) begin
      node_a_r <= node_mem[u_idx];
      node_b_r <= node_mem[v_idx];
    end else if (state_r == S_OREAD) begin
      node_a_r <= node_mem[i_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_NREAD) begin
      skip_r <= (8'(edge_rd_r.tail) >= 8'(n_r)) || (8'(edge_rd_r.head) >= 8'(n_r)) ||
                !reached_r[u_idx];
    end
    if (state_r == S_CALC) begin
      cand_r <= sat_dist(sum_w);
    end
  end

endmodule

FILE: rtl/ssp_checker.sv
// ---------------------------------------------------------------------------
// Shortest path unit port checker
// Watches the channels of the unit and flags sequencing errors.
// ---------------------------------------------------------------------------
`include "single_source_shortest_paths_unit_assert.svh"

module ssp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input ssp_pkg::edge_item_t   in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input ssp_pkg::node_result_t out_data
);
  import ssp_pkg::*;

  `SSP_ASSERT_ALL(a_reset_quiet, !rst_n |=> !out_valid, "result valid right after reset")

  // Results of one graph never overlap the loading of the next.
  `SSP_ASSERT_CLK(a_no_load_during_out, out_valid |-> in_stall, "input open while results pending")

  `SSP_ASSERT_CLK(a_edge_keeps_loading, (in_valid && !in_stall && !in_data.last_edge) |=> !in_stall, "stall after a plain edge request")

  `SSP_ASSERT_CLK(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "stalled result changed")

  `SSP_ASSERT_CLK(a_one_result_at_once, (out_valid && !out_stall) |=> !out_valid, "result valid right after a taken result")

endmodule

bind single_source_shortest_paths_unit ssp_checker u_ssp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
